FILE: hw/rtl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types and constants for the five-point heat stencil block.
// ----------------------------------------------------------------------------
package hst_pkg;

  localparam int DATA_W    = 32;  // Q8.24 sample width
  localparam int SUM_W     = 34;  // sum of four neighbors
  localparam int PROD_W    = 64;
  localparam int POS_W     = 10;  // row / col field width on the result bus
  localparam int GRID_W    = 11;
  localparam int COEF_W    = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int FRAC_BITS = 24;
  localparam int N_MAX_DEF = 1024;

  localparam logic [GRID_W-1:0] GRID_RST = 11'd1024;
  localparam logic [COEF_W-1:0] COEF_RST = 26'd1677722;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COEF = 2'd1;

  // One stencil evaluation handed to the arithmetic pipe
  typedef struct packed {
    logic signed [DATA_W-1:0] centre;
    logic signed [SUM_W-1:0]  nsum;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic                     last;
  } cell_op_t;

  // Centre weight 1 - 4r, exact in 32 signed bits for any 26-bit r
  function automatic logic signed [DATA_W-1:0] centre_weight(logic [COEF_W-1:0] coef);
    logic signed [DATA_W-1:0] one;
    logic signed [DATA_W-1:0] four_r;
    one    = DATA_W'(1) <<< FRAC_BITS;
    four_r = $signed({{(DATA_W-COEF_W-2){1'b0}}, coef, 2'b00});
    return one - four_r;
  endfunction

endpackage

FILE: hw/rtl/hst_window.sv
// ----------------------------------------------------------------------------
// hst_window
// Raster position, two line buffers and the 3x3 neighborhood window. Each
// accepted sample is captured with its neighbors; the zero to three cells it
// releases are then issued one per cycle while op_ready is high.
// ----------------------------------------------------------------------------
module hst_window #(
  parameter int N_MAX = hst_pkg::N_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             restart,
  input  logic [hst_pkg::GRID_W-1:0]       grid_size,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic signed [hst_pkg::DATA_W-1:0] in_sample,
  output logic                             op_valid,
  input  logic                             op_ready,
  output hst_pkg::cell_op_t                op
);

  localparam int IDX_W = (N_MAX > 2) ? $clog2(N_MAX) : 1;
  localparam int SZ_W  = IDX_W + 1;
  localparam int DW    = hst_pkg::DATA_W;
  localparam int SW    = hst_pkg::SUM_W;
  localparam int PW    = hst_pkg::POS_W;

  // pending cell bits
  localparam int CELL_ABOVE = 0;  // (j-1, i)
  localparam int CELL_LEFT  = 1;  // (n-1, i-1)
  localparam int CELL_HERE  = 2;  // (n-1, n-1)

  logic [SZ_W-1:0]  n_eff;
  logic [IDX_W-1:0] n_m1;
  logic [IDX_W-1:0] row_r, col_r, row_nxt, col_nxt, ra1;
  logic             last_col, last_row, accept;

  logic signed [DW-1:0] line1_mem [N_MAX];
  logic signed [DW-1:0] line2_mem [N_MAX];
  logic signed [DW-1:0] q1_r, q2_r;
  logic signed [DW-1:0] left_r, center_r, first_r, rec0_r, rec1_r;

  logic signed [DW-1:0] it_s_r, it_c_r, it_l_r, it_r_r, it_u_r, it_rec0_r, it_rec1_r;
  logic [IDX_W-1:0]     it_row_r, it_col_r;
  logic [2:0]           pend_r, pend_nxt, sel, mask;

  logic signed [DW-1:0] a0, a1, a2, a3, ctr;
  logic [IDX_W-1:0]     o_row, o_col;

  always_comb begin
    if (grid_size < hst_pkg::GRID_W'(2)) begin
      n_eff = SZ_W'(2);
    end else if (32'(grid_size) > 32'(N_MAX)) begin
      n_eff = SZ_W'(N_MAX);
    end else begin
      n_eff = SZ_W'(grid_size);
    end
  end

  assign n_m1     = IDX_W'(n_eff - SZ_W'(1));
  assign last_col = (col_r == n_m1);
  assign last_row = (row_r == n_m1);
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + IDX_W'(1);
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  // right neighbor of the next position comes from the row above
  assign ra1 = col_nxt + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line buffers: write-first on line1 covers the two-column grid
  always_ff @(posedge clk) begin
    if (accept) begin
      line1_mem[col_r] <= in_sample;
      line2_mem[col_r] <= center_r;
    end
    q1_r <= (accept && ra1 == col_r) ? in_sample : line1_mem[ra1];
    q2_r <= line2_mem[col_nxt];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_r   <= center_r;
      center_r <= last_col ? first_r : q1_r;
      if (col_r == '0) begin
        first_r <= in_sample;
      end
      rec1_r <= rec0_r;
      rec0_r <= in_sample;
    end
  end

  // which cells this sample releases
  always_comb begin
    mask             = '0;
    mask[CELL_ABOVE] = (row_r != '0);
    mask[CELL_LEFT]  = last_row && (col_r != '0);
    mask[CELL_HERE]  = last_row && last_col;
  end

  // item capture, neighbors outside the grid forced to zero
  always_ff @(posedge clk) begin
    if (accept) begin
      it_s_r    <= in_sample;
      it_c_r    <= center_r;
      it_l_r    <= (col_r != '0) ? left_r : '0;
      it_r_r    <= last_col ? '0 : q1_r;
      it_u_r    <= (32'(row_r) >= 32'd2) ? q2_r : '0;
      it_rec0_r <= rec0_r;
      it_rec1_r <= (32'(col_r) >= 32'd2) ? rec1_r : '0;
      it_row_r  <= row_r;
      it_col_r  <= col_r;
    end
  end

  always_comb begin
    if (pend_r[CELL_ABOVE]) begin
      sel = 3'b001;
    end else if (pend_r[CELL_LEFT]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end
  end

  assign op_valid  = (pend_r != '0);
  assign in_tready = (pend_r == '0) || (op_ready && ((pend_r & ~sel) == '0));

  always_comb begin
    pend_nxt = pend_r;
    if (op_valid && op_ready) begin
      pend_nxt = pend_r & ~sel;
    end
    if (accept) begin
      pend_nxt = mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    if (sel[CELL_ABOVE]) begin
      ctr   = it_c_r;
      a0    = it_l_r;
      a1    = it_r_r;
      a2    = it_u_r;
      a3    = it_s_r;
      o_row = it_row_r - IDX_W'(1);
      o_col = it_col_r;
    end else if (sel[CELL_LEFT]) begin
      ctr   = it_rec0_r;
      a0    = it_rec1_r;
      a1    = it_s_r;
      a2    = it_l_r;
      a3    = '0;
      o_row = it_row_r;
      o_col = it_col_r - IDX_W'(1);
    end else begin
      ctr   = it_s_r;
      a0    = it_rec0_r;
      a1    = '0;
      a2    = it_c_r;
      a3    = '0;
      o_row = it_row_r;
      o_col = it_col_r;
    end
  end

  always_comb begin
    op.centre = ctr;
    op.nsum   = SW'(a0) + SW'(a1) + SW'(a2) + SW'(a3);
    op.row    = PW'(o_row);
    op.col    = PW'(o_col);
    op.last   = ((pend_r & ~sel) == '0);
  end

endmodule

FILE: hw/rtl/hst_cell_alu.sv
// ----------------------------------------------------------------------------
// hst_cell_alu
// Three-stage stencil arithmetic: operand register, product register, then
// shift, add and saturate into the result register.
// ----------------------------------------------------------------------------
module hst_cell_alu (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [hst_pkg::COEF_W-1:0]         coef,
  input  logic signed [hst_pkg::DATA_W-1:0]  cweight,
  input  logic                               op_valid,
  output logic                               op_ready,
  input  hst_pkg::cell_op_t                  op,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic signed [hst_pkg::DATA_W-1:0]  res_value,
  output logic [hst_pkg::POS_W-1:0]          res_row,
  output logic [hst_pkg::POS_W-1:0]          res_col,
  output logic                               res_last
);

  localparam int DW = hst_pkg::DATA_W;
  localparam int PW = hst_pkg::PROD_W;
  localparam logic signed [PW-1:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [PW-1:0] SAT_LO = -64'sd2147483648;

  logic                 v1_r, v2_r, v3_r;
  logic                 en1, en2, en3;
  hst_pkg::cell_op_t    op1_r;
  logic signed [DW-1:0] centre1;
  logic signed [hst_pkg::SUM_W-1:0] nsum1;
  logic signed [hst_pkg::COEF_W:0]  coef_s;
  logic signed [PW-1:0] p1_nxt, p2_nxt, p1_r, p2_r, acc;
  logic [hst_pkg::POS_W-1:0] row2_r, col2_r;
  logic                 last2_r;
  logic signed [DW-1:0] value_nxt;

  assign en3      = !v3_r || res_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign op_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= op_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && op_valid) begin
      op1_r <= op;
    end
  end

  assign centre1 = op1_r.centre;
  assign nsum1   = op1_r.nsum;
  assign coef_s  = $signed({1'b0, coef});
  assign p1_nxt  = cweight * centre1;
  assign p2_nxt  = coef_s * nsum1;

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      row2_r  <= op1_r.row;
      col2_r  <= op1_r.col;
      last2_r <= op1_r.last;
    end
  end

  // arithmetic shifts round toward minus infinity
  always_comb begin
    acc = (p1_r >>> hst_pkg::FRAC_BITS) + (p2_r >>> hst_pkg::FRAC_BITS);
    if (acc > SAT_HI) begin
      value_nxt = SAT_HI[DW-1:0];
    end else if (acc < SAT_LO) begin
      value_nxt = SAT_LO[DW-1:0];
    end else begin
      value_nxt = acc[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      res_value <= value_nxt;
      res_row   <= row2_r;
      res_col   <= col2_r;
      res_last  <= last2_r;
    end
  end

  assign res_valid = v3_r;

endmodule

FILE: hw/rtl/heat_stencil_5pt_top.sv
// ----------------------------------------------------------------------------
// heat_stencil_5pt_top
// One explicit heat-equation step on a square grid with a five-point stencil.
// ----------------------------------------------------------------------------
// Usage:
//   Samples (signed Q8.24) enter on in_* in raster order. Each result leaves
//   on out_* with its value, row and column; out_tlast marks the final result
//   released by one input. Neighbors outside the grid count as zero.
//   Results lag the input by one row: row 0 releases nothing, later rows
//   release the cell above, and the last row also releases its own cells.
//   cfg_* writes grid_size (index 0, restarts the raster at 0,0) and
//   neighbor_coef (index 1, r in unsigned Q2.24); write only while idle.
//   Throughput: one input per cycle while out_* does not stall; a last-row
//   input past column 0 releases two cells and the final input of a grid
//   three, which the single multiply pipe issues one per cycle, holding off the
//   next input. A result passes the item, operand, product and result registers.
//   Reset restores grid_size 1024 and r = 0.1 and puts the raster at 0,0; the
//   line buffers are not cleared and need no clearing pass.
//   A stalled out_tready holds the result register and back-pressures the
//   pipe; in_tready drops once every stage is full and a released cell waits.
// ----------------------------------------------------------------------------
module heat_stencil_5pt_top #(
  parameter int N_MAX = hst_pkg::N_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,   // [31:0] sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [55:0]                         out_tdata,  // [31:0] value, [41:32] row,
                                                          // [51:42] col, [55:52] zero
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hst_pkg::CFG_DAT_W-1:0]       cfg_data
);

  logic [hst_pkg::GRID_W-1:0]        grid_size_r;
  logic [hst_pkg::COEF_W-1:0]        coef_r;
  logic signed [hst_pkg::DATA_W-1:0] cweight_r;
  logic                              cfg_we, restart;
  logic                              op_valid, op_ready;
  hst_pkg::cell_op_t                 op;
  logic signed [hst_pkg::DATA_W-1:0] res_value;
  logic [hst_pkg::POS_W-1:0]         res_row, res_col;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == hst_pkg::REG_GRID_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= hst_pkg::GRID_RST;
      coef_r      <= hst_pkg::COEF_RST;
      cweight_r   <= hst_pkg::centre_weight(hst_pkg::COEF_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hst_pkg::REG_GRID_SIZE: grid_size_r <= cfg_data[hst_pkg::GRID_W-1:0];
        hst_pkg::REG_NEIGHBOR_COEF: begin
          coef_r    <= cfg_data[hst_pkg::COEF_W-1:0];
          cweight_r <= hst_pkg::centre_weight(cfg_data[hst_pkg::COEF_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  hst_window #(
    .N_MAX (N_MAX)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .grid_size (grid_size_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample ($signed(in_tdata)),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op)
  );

  hst_cell_alu u_alu (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .cweight   (cweight_r),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_value (res_value),
    .res_row   (res_row),
    .res_col   (res_col),
    .res_last  (out_tlast)
  );

  assign out_tdata = {4'b0000, res_col, res_row, res_value};

endmodule
